>>> hw/rtl/bs_pkg.sv
// Package for the bucket sorter: sizes, index widths and the sequencer states.
// No dependencies; bucket_sorter imports it and both channel interfaces use it.
package bs_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    ST_LOAD,   // collect elements
    ST_PICK,   // read candidate element
    ST_CAND,   // latch candidate, start scan
    ST_SCAN,   // count elements ranked below the candidate
    ST_PLACE,  // write candidate at its rank
    ST_EREAD,  // read next sorted element
    ST_ELOAD,  // latch it into the output register
    ST_EWAIT   // hold result until transfer
  } state_t;

endpackage

>>> hw/rtl/bs_in_if.sv
// Input channel of the bucket sorter: valid/ready plus one element.
// Depends on bs_pkg.
interface bs_in_if;
  logic                         valid;
  logic                         ready;
  logic [bs_pkg::VALUE_BITS-1:0] sample_value;
  logic                         final_item;
  modport source (output valid, sample_value, final_item, input ready);
  modport sink   (input valid, sample_value, final_item, output ready);
endinterface

>>> hw/rtl/bs_out_if.sv
// Result channel of the bucket sorter: valid/ready plus one sorted element.
// Depends on bs_pkg.
interface bs_out_if;
  logic                         valid;
  logic                         ready;
  logic [bs_pkg::VALUE_BITS-1:0] sorted_value;
  logic                         final_result;
  logic                         overflowed;
  modport source (output valid, sorted_value, final_result, overflowed, input ready);
  modport sink   (input valid, sorted_value, final_result, overflowed, output ready);
endinterface

>>> hw/rtl/bucket_sorter.sv
// Bucket sorter top level: load sequencer, rank sort and ordered emit.
// Depends on bs_pkg, bs_in_if, bs_out_if and bs_ram.
//
//  channel | dir | transfer fields
//  in_s    | in  | sample_value, final_item
//  out_s   | out | sorted_value, final_result, overflowed
//
// Loading takes one element per cycle. After the marked element, each stored
// element is ranked by a scan of the element memory (one read per cycle), then
// written at its rank; once all are placed, results are emitted in order, each
// held until the output takes it. Reset is synchronous and clears the sequencer,
// count and drop flag. No input is taken while a set is sorting or emitting.
module bucket_sorter (
  input  logic    clk,
  input  logic    rst_n,
  bs_in_if.sink   in_s,
  bs_out_if.source out_s
);
  import bs_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   drop_r, drop_nxt;
  idx_t   i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt, e_r, e_nxt;
  value_t cand_r, cand_nxt, oval_r, oval_nxt;

  logic   e_we, b_we;
  idx_t   e_waddr, e_raddr, b_raddr;
  value_t e_rdata, b_rdata;
  cnt_t   last_idx;
  logic   in_xfer, out_xfer;

  // element memory: loaded values
  bs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_elem (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(in_s.sample_value),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // sorted memory: values at their rank
  bs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_sorted (
    .clk, .we(b_we), .waddr(rank_r), .wdata(cand_r),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  assign last_idx  = cnt_r - cnt_t'(1);
  assign in_s.ready = (state_r == ST_LOAD) && rst_n;
  assign in_xfer   = in_s.valid && in_s.ready;
  assign out_s.valid = (state_r == ST_EWAIT);
  assign out_xfer  = out_s.valid && out_s.ready;
  assign out_s.sorted_value = oval_r;
  assign out_s.final_result = (cnt_t'(e_r) == last_idx);
  assign out_s.overflowed   = drop_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    rank_r <= rank_nxt;
    e_r    <= e_nxt;
    cand_r <= cand_nxt;
    oval_r <= oval_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    rank_nxt  = rank_r;
    e_nxt     = e_r;
    cand_nxt  = cand_r;
    oval_nxt  = oval_r;
    e_we      = 1'b0;
    e_waddr   = cnt_r[IDX_W-1:0];
    e_raddr   = i_r;
    b_we      = 1'b0;
    b_raddr   = e_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (cnt_r < cnt_t'(MAX_ITEMS)) begin
            e_we    = 1'b1;
            cnt_nxt = cnt_r + cnt_t'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_s.final_item) begin
            i_nxt = '0;
            if (cnt_nxt == '0) begin
              drop_nxt = 1'b0;  // empty set: nothing to emit
            end else begin
              state_nxt = ST_PICK;
            end
          end
        end
      end
      ST_PICK: begin
        e_raddr   = i_r;
        state_nxt = ST_CAND;
      end
      ST_CAND: begin
        cand_nxt  = e_rdata;
        e_raddr   = '0;
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // e_rdata holds element j; ties broken by load order
        if ((e_rdata < cand_r) || ((e_rdata == cand_r) && (j_r < i_r))) begin
          rank_nxt = rank_r + idx_t'(1);
        end
        e_raddr = j_r + idx_t'(1);
        if (cnt_t'(j_r) == last_idx) begin
          state_nxt = ST_PLACE;
        end else begin
          j_nxt = j_r + idx_t'(1);
        end
      end
      ST_PLACE: begin
        b_we = 1'b1;
        if (cnt_t'(i_r) == last_idx) begin
          e_nxt     = '0;
          state_nxt = ST_EREAD;
        end else begin
          i_nxt     = i_r + idx_t'(1);
          state_nxt = ST_PICK;
        end
      end
      ST_EREAD: begin
        b_raddr   = e_r;
        state_nxt = ST_ELOAD;
      end
      ST_ELOAD: begin
        oval_nxt  = b_rdata;
        state_nxt = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (out_xfer) begin
          if (cnt_t'(e_r) == last_idx) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            e_nxt     = e_r + idx_t'(1);
            state_nxt = ST_EREAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_s.ready && out_s.valid))
    else $error("input and output active together");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(MAX_ITEMS))
    else $error("element count out of range");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> (cnt_r != '0))
    else $error("result from empty set");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_s.final_result) |=> (cnt_r == '0 && !drop_r))
    else $error("set not cleared after last result");

endmodule

>>> hw/rtl/bs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
